// ===== rtl/issm_pkg.sv =====
// ----------------------------------------------------------------------------
// issm_pkg
// Shared sizes, operation codes and pipeline types of the sorted-set lookup.
// ----------------------------------------------------------------------------
package issm_pkg;

	localparam int BLOCK_COUNT = 64;
	localparam int BLOCK_SIZE  = 64;   // a power of two: word address splits by bits
	localparam int DATA_DEPTH  = BLOCK_COUNT * BLOCK_SIZE;

	localparam int WORD_W    = 16;
	localparam int ADDR_W    = 12;
	localparam int OP_W      = 2;
	localparam int BLK_NUM_W = 7;

	localparam int IDX_W  = $clog2(BLOCK_COUNT);
	localparam int OFS_W  = $clog2(BLOCK_SIZE);
	localparam int BLK_W  = $clog2(BLOCK_COUNT + 1);
	localparam int PRB_W  = BLK_W + 1;
	// search levels: quarter size runs BLOCK_COUNT/4 down to 1
	localparam int LEVELS = ($clog2(BLOCK_COUNT + 1) - 1) / 2;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_DATA  = 2'd0,
		OP_WRITE_INDEX = 2'd1,
		OP_QUERY       = 2'd2
	} op_t;

	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] value;
		logic [PRB_W-1:0]  base;
	} item_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [BLK_W-1:0] blk;
	} res_t;

	function automatic logic idx_addr_ok(logic [ADDR_W-1:0] a);
		return 32'(a) < 32'(BLOCK_COUNT);
	endfunction

	function automatic logic data_addr_ok(logic [ADDR_W-1:0] a);
		return 32'(a) < 32'(DATA_DEPTH);
	endfunction

endpackage

// ===== rtl/issm_if.sv =====
// ----------------------------------------------------------------------------
// issm request and response channels
// Valid/ready channels carrying lookup requests and lookup responses.
// ----------------------------------------------------------------------------
interface issm_req_if import issm_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [ADDR_W-1:0] address;
	logic [WORD_W-1:0] value;

	modport source (output valid, output operation, output address, output value,
		input ready);
	modport sink (input valid, input operation, input address, input value,
		output ready);
endinterface

interface issm_rsp_if import issm_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [BLK_NUM_W-1:0] block_number;

	modport source (output valid, output found, output block_number, input ready);
	modport sink (input valid, input found, input block_number, output ready);
endinterface

// ===== rtl/indexed_sorted_set_membership.sv =====
// ----------------------------------------------------------------------------
// indexed_sorted_set_membership
// Sorted-set membership lookup: quaternary search of a block index followed
// by an equality scan of the chosen block, fully pipelined.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake      payload
// req      in   valid / ready  operation, address, value
// rsp      out  valid / ready  found, block_number (queries only)
//
// one request enters per cycle unless the pipeline is stalled; writes give
// no response; the depth is set by an input stage, two stages per search
// level (key read, compare), two for the final key and three for the block
// row read and scan
// the whole pipeline advances together while the response register is empty
// or being taken, so a stall holds every stage in place
// reset clears only the stage valid bits; index and data stores start
// undefined and are loaded by write requests
// ----------------------------------------------------------------------------
module indexed_sorted_set_membership import issm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	issm_req_if.sink   req,
	issm_rsp_if.source rsp
);

	logic adv;

	// lvl_s[l]: request entering search level l; lvl_s[0] is the input stage
	item_t             lvl_s [LEVELS+1];
	item_t             rd_s  [LEVELS];
	logic [WORD_W-1:0] key_s [LEVELS][3];
	logic              inr_s [LEVELS][3];

	item_t             fin_s;
	logic [WORD_W-1:0] fkey_s;
	logic [WORD_W-1:0] fin_mem [BLOCK_COUNT];

	item_t             chk_s;
	logic [BLK_W-1:0]  chk_blk_s;

	res_t res;

	// every stage moves when the response register is free
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_s[0].valid <= 1'b0;
		end else if (adv) begin
			lvl_s[0].valid <= req.valid;
			lvl_s[0].op    <= op_t'(req.operation);
			lvl_s[0].addr  <= req.address;
			lvl_s[0].value <= req.value;
			lvl_s[0].base  <= '0;
		end
	end

	// search levels: each holds its own copies of the index, one per probe,
	// so index writes reach every copy in request order
	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		localparam int Q = BLOCK_COUNT >> (2 * l + 2);

		logic [2:0]       below;
		logic [1:0]       cnt;
		logic [PRB_W-1:0] step;
		item_t            nxt;

		for (genvar j = 0; j < 3; j++) begin : g_key
			logic [WORD_W-1:0] mem [BLOCK_COUNT];
			logic [PRB_W-1:0]  probe;
			logic              probe_ok;

			assign probe    = lvl_s[l].base + PRB_W'((j + 1) * Q);
			// a probe past the last block never counts as below the query
			assign probe_ok = probe < PRB_W'(BLOCK_COUNT);

			always_ff @(posedge clk) begin
				if (adv) begin
					if (lvl_s[l].valid && lvl_s[l].op == OP_WRITE_INDEX &&
							idx_addr_ok(lvl_s[l].addr)) begin
						mem[lvl_s[l].addr[IDX_W-1:0]] <= lvl_s[l].value;
					end
					if (lvl_s[l].valid && lvl_s[l].op == OP_QUERY && probe_ok) begin
						key_s[l][j] <= mem[probe[IDX_W-1:0]];
					end
					inr_s[l][j] <= probe_ok;
				end
			end

			assign below[j] = inr_s[l][j] && (key_s[l][j] < rd_s[l].value);
		end

		// keys below the query, times the quarter size
		assign cnt  = 2'($countones(below));
		assign step = PRB_W'(cnt) * PRB_W'(Q);

		// request for the next level with its base moved on
		always_comb begin
			nxt      = rd_s[l];
			nxt.base = rd_s[l].base + step;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rd_s[l].valid      <= 1'b0;
				lvl_s[l + 1].valid <= 1'b0;
			end else if (adv) begin
				rd_s[l]      <= lvl_s[l];
				lvl_s[l + 1] <= nxt;
			end
		end
	end

	// last key: block is base, or base+1 when its key is below the query
	always_ff @(posedge clk) begin
		if (adv) begin
			if (lvl_s[LEVELS].valid && lvl_s[LEVELS].op == OP_WRITE_INDEX &&
					idx_addr_ok(lvl_s[LEVELS].addr)) begin
				fin_mem[lvl_s[LEVELS].addr[IDX_W-1:0]] <= lvl_s[LEVELS].value;
			end
			if (lvl_s[LEVELS].valid && lvl_s[LEVELS].op == OP_QUERY) begin
				fkey_s <= fin_mem[lvl_s[LEVELS].base[IDX_W-1:0]];
			end
			chk_blk_s <= BLK_W'(fin_s.base) + BLK_W'(fkey_s < fin_s.value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s.valid <= 1'b0;
			chk_s.valid <= 1'b0;
		end else if (adv) begin
			fin_s <= lvl_s[LEVELS];
			chk_s <= fin_s;
		end
	end

	// data row read, equality scan, response register
	issm_block_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (chk_s),
		.blk    (chk_blk_s),
		.res    (res)
	);

	assign rsp.valid        = res.valid;
	assign rsp.found        = res.found;
	assign rsp.block_number = BLK_NUM_W'(res.blk);

	// search never runs past one block beyond the last
	a_blk_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.blk <= BLK_W'(BLOCK_COUNT))
		else $error("block number beyond range");

	// beyond the last block there is nothing to find
	a_beyond_absent: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.blk == BLK_W'(BLOCK_COUNT) |-> !res.found)
		else $error("found set beyond last block");

	// after the last level the base names an existing index entry
	a_base_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_s[LEVELS].valid && lvl_s[LEVELS].op == OP_QUERY |->
		lvl_s[LEVELS].base < PRB_W'(BLOCK_COUNT))
		else $error("search base past index");

	// a held pipeline keeps its input stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(lvl_s[0]))
		else $error("input stage moved during stall");

endmodule

// ===== rtl/issm_block_check.sv =====
// ----------------------------------------------------------------------------
// issm_block_check
// Data store held as one row per block; reads the chosen row and looks for
// a word equal to the query in three pipeline stages.
// ----------------------------------------------------------------------------
module issm_block_check import issm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  item_t            item,
	input  logic [BLK_W-1:0] blk,
	output res_t             res
);

	logic [WORD_W-1:0] row_mem [BLOCK_COUNT][BLOCK_SIZE];

	logic [IDX_W-1:0]  wr_row;
	logic [OFS_W-1:0]  wr_col;
	logic              blk_ok;

	logic              q_s1;
	logic [WORD_W-1:0] row_s1 [BLOCK_SIZE];
	logic [WORD_W-1:0] val_s1;
	logic [BLK_W-1:0]  blk_s1;
	logic              ok_s1;

	logic                  q_s2;
	logic [BLOCK_SIZE-1:0] match_s2;
	logic [BLK_W-1:0]      blk_s2;
	logic                  ok_s2;

	logic             valid_s3;
	logic             found_s3;
	logic [BLK_W-1:0] blk_s3;

	assign wr_row = IDX_W'(item.addr >> OFS_W);
	assign wr_col = item.addr[OFS_W-1:0];
	assign blk_ok = blk < BLK_W'(BLOCK_COUNT);

	// row store: one word written, one whole row read
	always_ff @(posedge clk) begin
		if (adv) begin
			if (item.valid && item.op == OP_WRITE_DATA && data_addr_ok(item.addr)) begin
				row_mem[wr_row][wr_col] <= item.value;
			end
			if (item.valid && item.op == OP_QUERY && blk_ok) begin
				row_s1 <= row_mem[blk[IDX_W-1:0]];
			end
			val_s1 <= item.value;
			blk_s1 <= blk;
			ok_s1  <= blk_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < BLOCK_SIZE; k++) begin
				match_s2[k] <= row_s1[k] == val_s1;
			end
			blk_s2   <= blk_s1;
			ok_s2    <= ok_s1;
			found_s3 <= ok_s2 && (|match_s2);
			blk_s3   <= blk_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_s1     <= 1'b0;
			q_s2     <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			q_s1     <= item.valid && item.op == OP_QUERY;
			q_s2     <= q_s1;
			valid_s3 <= q_s2;
		end
	end

	assign res = '{valid: valid_s3, found: found_s3, blk: blk_s3};

endmodule
